FILE: hdl/cmcb_pkg.sv
package cmcb_pkg;

    localparam int COLOR_W    = 8;
    localparam int COORD_W    = 12;
    localparam int COUNT_W    = 24;
    localparam int SUM_W      = 36;
    localparam int BOX_W      = 13;
    localparam int FW_W       = 13;
    localparam int HALF_W     = 8;
    localparam int IDX_W      = 3;
    localparam int CFG_DATA_W = 13;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 104;
    // quotient is a mean coordinate, so it never needs more than COORD_W bits
    localparam int Q_STEPS    = COORD_W;
    localparam int STEP_W     = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_BLUE  = 3'd0,
        REG_TARGET_GREEN = 3'd1,
        REG_TARGET_RED   = 3'd2,
        REG_FRAME_WIDTH  = 3'd3,
        REG_BOX_HALF     = 3'd4
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic [COLOR_W-1:0] target_blue;
        logic [COLOR_W-1:0] target_green;
        logic [COLOR_W-1:0] target_red;
        logic [FW_W-1:0]    frame_width;
        logic [HALF_W-1:0]  box_half;
    } cfg_t;

    typedef struct packed {
        logic pix_take;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/cmcb_ctrl.sv
module cmcb_ctrl
    import cmcb_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    input  logic s_tlast,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t             state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACCUM;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_ACCUM: begin
                s_tready     = 1'b1;
                cmd.pix_take = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    cmd.div_start = 1'b1;
                    step_next     = '0;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(Q_STEPS - 1)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // wait here while the previous result is still unclaimed
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default: begin
                state_next = ST_ACCUM;
            end
        endcase
    end

endmodule

FILE: hdl/cmcb_datapath.sv
module cmcb_datapath
    import cmcb_pkg::*;
#(
    parameter int WIDTH_CAP = 4096,
    parameter int ROW_LIMIT = 4095
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  cmd_t                cmd,
    output sts_t                sts,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser
);

    logic [COORD_W-1:0] column_reg, column_next;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [SUM_W-1:0]   sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]   sum_y_reg, sum_y_next;
    logic [COUNT_W-1:0] hit_count_reg, hit_count_next;

    logic [SUM_W-1:0]   rem_x_reg, rem_y_reg, dvs_reg;
    logic [COORD_W-1:0] qx_reg, qy_reg;
    logic [COUNT_W-1:0] cnt_snap_reg;

    logic               out_valid_reg, out_valid_next;
    logic               found_reg;
    logic [COUNT_W-1:0] match_count_reg;
    logic [COORD_W-1:0] center_x_reg, center_y_reg;
    logic [BOX_W-1:0]   box_left_reg, box_top_reg, box_right_reg, box_bottom_reg;

    logic [FW_W-1:0]    eff_width;
    logic [FW_W-1:0]    col_inc;
    logic               hit;
    logic [SUM_W-1:0]   sum_x_acc, sum_y_acc;
    logic [COUNT_W-1:0] count_acc;
    logic               ge_x, ge_y;

    always_comb begin
        eff_width = cfg.frame_width;
        if (eff_width == '0) begin
            eff_width = FW_W'(1);
        end
        if (eff_width > FW_W'(WIDTH_CAP)) begin
            eff_width = FW_W'(WIDTH_CAP);
        end
    end

    assign col_inc = {1'b0, column_reg} + FW_W'(1);

    assign hit = (s_tdata[7:0]   == cfg.target_blue)  &&
                 (s_tdata[15:8]  == cfg.target_green) &&
                 (s_tdata[23:16] == cfg.target_red)   &&
                 (hit_count_reg != COUNT_MAX);

    // running totals including the pixel just taken
    always_comb begin
        sum_x_acc = sum_x_reg;
        sum_y_acc = sum_y_reg;
        count_acc = hit_count_reg;
        if (hit) begin
            sum_x_acc = sum_x_reg + SUM_W'(column_reg);
            sum_y_acc = sum_y_reg + SUM_W'(row_reg);
            count_acc = hit_count_reg + 1'b1;
        end
    end

    always_comb begin
        column_next    = column_reg;
        row_next       = row_reg;
        sum_x_next     = sum_x_reg;
        sum_y_next     = sum_y_reg;
        hit_count_next = hit_count_reg;
        if (cmd.pix_take) begin
            if (cmd.div_start) begin
                column_next    = '0;
                row_next       = '0;
                sum_x_next     = '0;
                sum_y_next     = '0;
                hit_count_next = '0;
            end else begin
                sum_x_next     = sum_x_acc;
                sum_y_next     = sum_y_acc;
                hit_count_next = count_acc;
                if (col_inc >= eff_width) begin
                    column_next = '0;
                    if (row_reg < COORD_W'(ROW_LIMIT)) begin
                        row_next = row_reg + 1'b1;
                    end
                end else begin
                    column_next = col_inc[COORD_W-1:0];
                end
            end
        end
    end

    assign sts.out_free   = !out_valid_reg || m_tready;
    assign out_valid_next = cmd.out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg    <= '0;
            row_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            hit_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            column_reg    <= column_next;
            row_reg       <= row_next;
            sum_x_reg     <= sum_x_next;
            sum_y_reg     <= sum_y_next;
            hit_count_reg <= hit_count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // restoring division, one quotient bit per cycle, x and y side by side
    assign ge_x = rem_x_reg >= dvs_reg;
    assign ge_y = rem_y_reg >= dvs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_x_reg    <= sum_x_acc;
            rem_y_reg    <= sum_y_acc;
            cnt_snap_reg <= count_acc;
            dvs_reg      <= SUM_W'({count_acc, {(Q_STEPS-1){1'b0}}});
            qx_reg       <= '0;
            qy_reg       <= '0;
        end else if (cmd.div_step) begin
            if (ge_x) begin
                rem_x_reg <= rem_x_reg - dvs_reg;
            end
            if (ge_y) begin
                rem_y_reg <= rem_y_reg - dvs_reg;
            end
            qx_reg  <= {qx_reg[COORD_W-2:0], ge_x};
            qy_reg  <= {qy_reg[COORD_W-2:0], ge_y};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cnt_snap_reg == '0) begin
                found_reg       <= 1'b0;
                match_count_reg <= '0;
                center_x_reg    <= '0;
                center_y_reg    <= '0;
                box_left_reg    <= '0;
                box_top_reg     <= '0;
                box_right_reg   <= '0;
                box_bottom_reg  <= '0;
            end else begin
                found_reg       <= 1'b1;
                match_count_reg <= cnt_snap_reg;
                center_x_reg    <= qx_reg;
                center_y_reg    <= qy_reg;
                box_left_reg    <= {1'b0, qx_reg} - BOX_W'(cfg.box_half);
                box_top_reg     <= {1'b0, qy_reg} - BOX_W'(cfg.box_half);
                box_right_reg   <= {1'b0, qx_reg} + BOX_W'(cfg.box_half);
                box_bottom_reg  <= {1'b0, qy_reg} + BOX_W'(cfg.box_half);
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = found_reg;
    assign m_tdata  = {4'b0, box_bottom_reg, box_right_reg, box_top_reg, box_left_reg,
                       center_y_reg, center_x_reg, match_count_reg};

    // a finished result must never overwrite one that is still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten while pending");

    // frame accumulators start over after the closing pixel
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> (hit_count_reg == '0 && column_reg == '0 && row_reg == '0))
        else $error("accumulators not cleared at frame end");

    // an empty frame reports all zeros
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !found_reg) |->
            (match_count_reg == '0 && center_x_reg == '0 && box_right_reg == '0))
        else $error("empty frame result not zero");

endmodule

FILE: hdl/color_match_centroid_box.sv
// the result is divided out after a frame's last pixel is accepted, then registered
// throughput: one pixel per cycle within a frame; after the last pixel the input
//   stalls while a 12-step shared restoring divider forms both means and the result
//   is loaded, longer if the previous result has not been taken yet
// reset: aresetn is synchronous, active low; clears counters, sums, state and the
//   output valid, and returns the configuration registers to their defaults
module color_match_centroid_box
    import cmcb_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // blue, green, red
    input  logic                  s_tlast,   // last_in_frame
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // match_count, center_x, center_y, box_left,
                                             // box_top, box_right, box_bottom, zero pad
    output logic                  m_tuser,   // found
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int WIDTH_CAP = (MAX_WIDTH > 4096) ? 4096 : MAX_WIDTH;
    localparam int ROW_LIMIT = (MAX_HEIGHT - 1 > 4095) ? 4095 : MAX_HEIGHT - 1;

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_TARGET_BLUE:  cfg_next.target_blue  = cfg_data[COLOR_W-1:0];
                REG_TARGET_GREEN: cfg_next.target_green = cfg_data[COLOR_W-1:0];
                REG_TARGET_RED:   cfg_next.target_red   = cfg_data[COLOR_W-1:0];
                REG_FRAME_WIDTH:  cfg_next.frame_width  = cfg_data[FW_W-1:0];
                REG_BOX_HALF:     cfg_next.box_half     = cfg_data[HALF_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_blue  <= 8'd255;
            cfg_reg.target_green <= 8'd255;
            cfg_reg.target_red   <= 8'd255;
            cfg_reg.frame_width  <= 13'd640;
            cfg_reg.box_half     <= 8'd35;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cmcb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cmcb_datapath #(
        .WIDTH_CAP (WIDTH_CAP),
        .ROW_LIMIT (ROW_LIMIT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import cmcb_pkg::*;

    localparam int WIDTH_TOP   = 4096;
    localparam int ROW_TOP     = 4095;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 30;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               last;
    } pixel_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [3:0]         pad;
        logic [BOX_W-1:0]   bottom;
        logic [BOX_W-1:0]   right;
        logic [BOX_W-1:0]   top;
        logic [BOX_W-1:0]   left;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] cx;
        logic [COUNT_W-1:0] count;
    } box_word_t;

    typedef struct packed {
        logic      found;
        box_word_t word;
    } blob_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;     // blue, green, red
    logic                  s_tlast = 1'b0;   // last_in_frame
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;          // match_count, center_x, center_y, box_left,
                                             // box_top, box_right, box_bottom, zero pad
    logic                  m_tuser;          // found
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    color_match_centroid_box i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // predictor copy of registers and frame state
    logic [COLOR_W-1:0] want_b, want_g, want_r;
    logic [FW_W-1:0]    width_reg;
    logic [HALF_W-1:0]  half_reg;
    logic [COORD_W-1:0] col_pos, row_pos;
    logic [SUM_W-1:0]   sum_x, sum_y;
    logic [COUNT_W-1:0] hit_cnt;

    blob_t  pending_blobs[$];
    pixel_t pix_q[$];

    // what the stimulus aims at, tracked apart from the predictor
    logic [COLOR_W-1:0] aim_b = 8'hFF, aim_g = 8'hFF, aim_r = 8'hFF;

    int  mismatches = 0;
    int  cycle_cnt = 0;
    int  hold_left = 0;
    bit  calm = 1'b0;
    bit  in_fire = 1'b0;

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] got,
                               input logic [COUNT_W-1:0] exp);
        if (got !== exp)
            report($sformatf("%s got 0x%0h expected 0x%0h", name, got, exp));
    endtask

    function automatic void clear_frame();
        col_pos = '0;
        row_pos = '0;
        sum_x   = '0;
        sum_y   = '0;
        hit_cnt = '0;
    endfunction

    function automatic void load_defaults();
        want_b    = 8'd255;
        want_g    = 8'd255;
        want_r    = 8'd255;
        width_reg = 13'd640;
        half_reg  = 8'd35;
        clear_frame();
    endfunction

    function automatic void apply_reg(input logic [IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TARGET_BLUE:  want_b    = data[COLOR_W-1:0];
            REG_TARGET_GREEN: want_g    = data[COLOR_W-1:0];
            REG_TARGET_RED:   want_r    = data[COLOR_W-1:0];
            REG_FRAME_WIDTH:  width_reg = data[FW_W-1:0];
            REG_BOX_HALF:     half_reg  = data[HALF_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int row_length();
        if (width_reg == 0)
            return 1;
        if (width_reg > WIDTH_TOP)
            return WIDTH_TOP;
        return int'(width_reg);
    endfunction

    // accumulate one pixel and, at end of frame, queue the centroid and box
    function automatic void track_pixel(input pixel_t px);
        blob_t res;
        logic [COORD_W-1:0] cx, cy;
        res = '0;
        if (px.b == want_b && px.g == want_g && px.r == want_r && hit_cnt != COUNT_MAX) begin
            sum_x   = sum_x + SUM_W'(col_pos);
            sum_y   = sum_y + SUM_W'(row_pos);
            hit_cnt = hit_cnt + 1'b1;
        end
        if (!px.last) begin
            if (int'(col_pos) + 1 >= row_length()) begin
                col_pos = '0;
                if (row_pos < ROW_TOP)
                    row_pos = row_pos + 1'b1;
            end else begin
                col_pos = col_pos + 1'b1;
            end
            return;
        end
        if (hit_cnt != 0) begin
            cx = COORD_W'(sum_x / SUM_W'(hit_cnt));
            cy = COORD_W'(sum_y / SUM_W'(hit_cnt));
            res.found       = 1'b1;
            res.word.count  = hit_cnt;
            res.word.cx     = cx;
            res.word.cy     = cy;
            res.word.left   = BOX_W'(cx) - BOX_W'(half_reg);
            res.word.top    = BOX_W'(cy) - BOX_W'(half_reg);
            res.word.right  = BOX_W'(cx) + BOX_W'(half_reg);
            res.word.bottom = BOX_W'(cy) + BOX_W'(half_reg);
        end
        pending_blobs.push_back(res);
        clear_frame();
    endfunction

    // sample both channels at the rising edge
    always @(posedge aclk) begin
        box_word_t got;
        blob_t     want;
        cycle_cnt++;
        in_fire = aresetn && s_tvalid && s_tready;
        if (!aresetn)
            load_defaults();
        else if (cfg_valid && cfg_ready)
            apply_reg(cfg_index, cfg_data);
        if (in_fire)
            track_pixel(pixel_t'({s_tdata[23:16], s_tdata[15:8], s_tdata[7:0], s_tlast}));
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blobs.size() == 0) begin
                report("result transaction with no frame pending");
            end else begin
                want = pending_blobs.pop_front();
                got  = box_word_t'(m_tdata);
                check_field("found", COUNT_W'(m_tuser), COUNT_W'(want.found));
                check_field("match_count", got.count, want.word.count);
                check_field("center_x", COUNT_W'(got.cx), COUNT_W'(want.word.cx));
                check_field("center_y", COUNT_W'(got.cy), COUNT_W'(want.word.cy));
                check_field("box_left", COUNT_W'(got.left), COUNT_W'(want.word.left));
                check_field("box_top", COUNT_W'(got.top), COUNT_W'(want.word.top));
                check_field("box_right", COUNT_W'(got.right), COUNT_W'(want.word.right));
                check_field("box_bottom", COUNT_W'(got.bottom), COUNT_W'(want.word.bottom));
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // pixel driver
    always @(negedge aclk) begin
        pixel_t px;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pix_q.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
                px = pix_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {px.r, px.g, px.b};
                s_tlast  <= px.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= calm || $urandom_range(99) >= 32;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_target(input logic [COLOR_W-1:0] b, g, r);
        write_reg(REG_TARGET_BLUE, {5'($urandom), b});
        write_reg(REG_TARGET_GREEN, {5'($urandom), g});
        write_reg(REG_TARGET_RED, {5'($urandom), r});
        aim_b = b;
        aim_g = g;
        aim_r = r;
    endtask

    task automatic add_pixel(input logic [23:0] rgb, input bit last);
        pix_q.push_back(pixel_t'({rgb, last}));
    endtask

    function automatic pixel_t make_pixel(input bit noisy, input bit last);
        logic [23:0] c;
        int k, flip;
        c = {aim_r, aim_g, aim_b};
        k = $urandom_range(99);
        if (noisy || k >= 60) begin
            c = 24'($urandom);
        end else if (k >= 45) begin
            flip = $urandom_range(23);
            c[flip] = ~c[flip];
        end
        return pixel_t'({c, last});
    endfunction

    task automatic queue_frames(input int n_pix, input int max_len);
        int remain, len;
        bit noisy;
        remain = n_pix;
        while (remain > 0) begin
            len = $urandom_range(1, max_len);
            if (len > remain)
                len = remain;
            noisy = ($urandom_range(9) == 0);
            for (int i = 0; i < len; i++)
                pix_q.push_back(make_pixel(noisy, i == len - 1));
            remain -= len;
        end
    endtask

    task automatic wait_idle();
        while (pix_q.size() != 0 || s_tvalid || pending_blobs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic random_width();
        int k;
        k = $urandom_range(9);
        if (k == 0)
            write_reg(REG_FRAME_WIDTH, '0);
        else if (k == 1)
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(WIDTH_TOP, 8191)));
        else
            write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // defaults: white target, width 640, half 35
        add_pixel(24'hFFFFFF, 1'b1);
        add_pixel(24'h000000, 1'b1);
        add_pixel(24'hFFFFFF, 1'b0);
        add_pixel(24'h00FFFF, 1'b0);
        add_pixel(24'hFFFFFF, 1'b0);
        add_pixel(24'hFFFFFF, 1'b1);
        wait_idle();

        // black target, zero width acts as one column, widest box
        set_target(8'h00, 8'h00, 8'h00);
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_BOX_HALF, 13'h1FFF);
        for (int idx = int'(REG_BOX_HALF) + 1; idx < 2 ** IDX_W; idx++)
            write_reg(IDX_W'(idx), '1);
        end_writes();
        add_pixel(24'h000000, 1'b0);
        add_pixel(24'h000001, 1'b0);
        add_pixel(24'h000000, 1'b0);
        add_pixel(24'h800000, 1'b0);
        add_pixel(24'h000000, 1'b1);
        wait_idle();

        // one tall column, the row counter steps on every pixel
        write_reg(REG_BOX_HALF, '0);
        end_writes();
        for (int i = 0; i < 40; i++)
            add_pixel((i == 0 || i >= 36) ? 24'h000000 : 24'h00FF00, i == 39);
        wait_idle();

        // width above the maximum is held at the maximum
        write_reg(REG_FRAME_WIDTH, 13'h1FFF);
        write_reg(REG_BOX_HALF, 13'h1F80);
        end_writes();
        for (int i = 0; i < 40; i++)
            add_pixel(i >= 33 ? 24'h000000 : 24'hFF0000, i == 39);
        wait_idle();

        for (int ph = 0; ph < 6; ph++) begin
            set_target(8'($urandom), 8'($urandom), 8'($urandom));
            random_width();
            write_reg(REG_BOX_HALF, CFG_DATA_W'($urandom));
            end_writes();
            calm = (ph == 2);
            if (ph == 4) begin
                // short frames against a stalled receiver fill the block up
                queue_frames(90, 3);
                hold_left = 300;
            end else begin
                queue_frames(90, 40);
            end
            wait_idle();
        end
        calm = 1'b0;

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
